// ===== src/salc_pkg.sv =====
// Shared types and constants of the set-associative LRU cache tag block.
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;

  localparam int DEF_MAX_WAYS  = 8;
  localparam int DEF_MAX_SETS  = 1024;
  localparam int DEF_ADDR_BITS = 32;

  localparam int CMD_W     = 2;
  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 4;
  localparam int FETCH_W   = 6;
  localparam int COPY_W    = 19;
  localparam int NW_W      = 5;
  localparam int SB_W      = 5;

  localparam logic [COPY_W-1:0] COPY_MAX = {COPY_W{1'b1}};

  localparam logic       RST_SPLIT = 1'b0;
  localparam logic [2:0] RST_BO    = 3'd4;
  localparam logic [3:0] RST_WAYS  = 4'd1;
  localparam logic [3:0] RST_DSB   = 4'd9;
  localparam logic [3:0] RST_ISB   = 4'd9;
  localparam logic       RST_WB    = 1'b1;
  localparam logic       RST_WA    = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FETCH = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPLIT_MODE     = 3'd0,
    CFG_BLOCK_OFFSET   = 3'd1,
    CFG_WAYS           = 3'd2,
    CFG_DATA_SET_BITS  = 3'd3,
    CFG_INST_SET_BITS  = 3'd4,
    CFG_WRITE_BACK     = 3'd5,
    CFG_WRITE_ALLOCATE = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic               dirty_evicted;
    logic [FETCH_W-1:0] fetch_words;
    logic [COPY_W-1:0]  copyback_words;
  } result_t;

endpackage
`default_nettype wire

// ===== src/salc_if.sv =====
// Request and response channel interfaces of the cache tag block.
`timescale 1ns / 1ps
`default_nettype none
interface salc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] addr;
  modport source (output valid, cmd, addr, input ready);
  modport sink (input valid, cmd, addr, output ready);
endinterface

interface salc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        evicted;
  logic        dirty_evicted;
  logic [5:0]  fetch_words;
  logic [18:0] copyback_words;
  modport source (output valid, hit, evicted, dirty_evicted, fetch_words, copyback_words,
                  input ready);
  modport sink (input valid, hit, evicted, dirty_evicted, fetch_words, copyback_words,
                output ready);
endinterface
`default_nettype wire

// ===== src/salc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== src/salc_update.sv =====
// Lookup, LRU victim choice and new set contents for one access.
`timescale 1ns / 1ps
`default_nettype none
module salc_update import salc_pkg::*; #(
  parameter int MAX_WAYS = DEF_MAX_WAYS,
  parameter int TAG_W    = DEF_ADDR_BITS - 2,
  parameter int AGE_W    = 3
) (
  input  wire logic [MAX_WAYS*(AGE_W+TAG_W+2)-1:0] row_in,
  input  wire logic [TAG_W-1:0]                    tag,
  input  wire logic [NW_W-1:0]                     nw,
  input  wire logic                                is_write,
  input  wire logic                                write_back,
  input  wire logic                                write_allocate,
  input  wire logic [2:0]                          wpb_log,
  output logic      [MAX_WAYS*(AGE_W+TAG_W+2)-1:0] row_out,
  output result_t                                  res
);
  localparam int LINE_W = AGE_W + TAG_W + 2;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic             v    [MAX_WAYS];
  logic             d    [MAX_WAYS];
  logic [TAG_W-1:0] t    [MAX_WAYS];
  logic [AGE_W-1:0] a    [MAX_WAYS];
  logic             nv   [MAX_WAYS];
  logic             nd   [MAX_WAYS];
  logic [TAG_W-1:0] nt   [MAX_WAYS];
  logic [AGE_W-1:0] na   [MAX_WAYS];
  logic             hit;
  logic [WAY_W-1:0] hw;
  logic             inv_found;
  logic [WAY_W-1:0] iw;
  logic [WAY_W-1:0] ow;
  logic [AGE_W-1:0] oa;
  logic [WAY_W-1:0] sel;
  logic             do_touch;
  logic [AGE_W-1:0] ta;
  logic [FETCH_W-1:0] wpb;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      a[w] = row_in[w*LINE_W +: AGE_W];
      t[w] = row_in[w*LINE_W + AGE_W +: TAG_W];
      d[w] = row_in[w*LINE_W + AGE_W + TAG_W];
      v[w] = row_in[w*LINE_W + AGE_W + TAG_W + 1];
    end

    // Lowest matching way wins; ways beyond the configured count are not looked at.
    hit = 1'b0;
    hw  = '0;
    inv_found = 1'b0;
    iw  = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit && (w < int'(nw)) && v[w] && (t[w] == tag)) begin
        hit = 1'b1;
        hw  = WAY_W'(w);
      end
      if (!inv_found && (w < int'(nw)) && !v[w]) begin
        inv_found = 1'b1;
        iw = WAY_W'(w);
      end
    end

    ow = '0;
    oa = a[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if ((w < int'(nw)) && (a[w] > oa)) begin
        oa = a[w];
        ow = WAY_W'(w);
      end
    end

    wpb = FETCH_W'(1) << wpb_log;
    res = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      nv[w] = v[w];
      nd[w] = d[w];
      nt[w] = t[w];
    end
    sel = hw;
    do_touch = 1'b0;

    if (hit) begin
      res.hit = 1'b1;
      if (is_write) begin
        if (write_back) begin
          nd[hw] = 1'b1;
        end else begin
          res.copyback_words = COPY_W'(1);
        end
      end
      do_touch = 1'b1;
    end else if (is_write && !write_allocate) begin
      res.copyback_words = COPY_W'(1);
    end else begin
      if (inv_found) begin
        sel = iw;
      end else begin
        sel = ow;
        res.evicted = 1'b1;
        if (d[ow]) begin
          res.dirty_evicted  = 1'b1;
          res.copyback_words = COPY_W'(wpb);
        end
      end
      res.fetch_words = wpb;
      nv[sel] = 1'b1;
      nt[sel] = tag;
      nd[sel] = is_write && write_back;
      if (is_write && !write_back) begin
        res.copyback_words = res.copyback_words + COPY_W'(1);
      end
      do_touch = 1'b1;
    end

    // Ages are updated over every way of the set, in use or not.
    ta = a[sel];
    for (int w = 0; w < MAX_WAYS; w++) begin
      na[w] = (do_touch && (a[w] < ta)) ? a[w] + AGE_W'(1) : a[w];
    end
    if (do_touch) begin
      na[sel] = '0;
    end

    for (int w = 0; w < MAX_WAYS; w++) begin
      row_out[w*LINE_W +: LINE_W] = {nv[w], nd[w], nt[w], na[w]};
    end
  end
endmodule
`default_nettype wire

// ===== src/set_assoc_lru_cache_tags.sv =====
// Top level of the set-associative LRU cache tag block.
// An access first reads the indexed set's row from the tag RAM, then updates that row,
// writes it back and registers the result.
// A flush walks every set of the data RAM, one row a cycle.
// After reset a clearing pass writes every row of both RAMs, with no word accepted
// meanwhile; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_lru_cache_tags import salc_pkg::*; #(
  parameter int MAX_WAYS  = DEF_MAX_WAYS,
  parameter int MAX_SETS  = DEF_MAX_SETS,
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wen,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  salc_req_if.sink                  req,
  salc_rsp_if.source                rsp
);
  localparam int TAG_W  = ADDR_BITS - 2;
  localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_W = AGE_W + TAG_W + 2;
  localparam int ROW_W  = MAX_WAYS * LINE_W;
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int CNT_W  = $clog2(MAX_SETS + 1);
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int PC_W   = $clog2(MAX_WAYS + 1);
  localparam int LC_W   = $clog2(MAX_SETS * MAX_WAYS + 1);
  localparam int TOT_W  = LC_W + COPY_W;

  // Configuration registers.
  logic       split_mode;
  logic [2:0] block_offset_bits;
  logic [3:0] ways;
  logic [3:0] data_set_bits;
  logic [3:0] inst_set_bits;
  logic       write_back;
  logic       write_allocate;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_mode        <= RST_SPLIT;
      block_offset_bits <= RST_BO;
      ways              <= RST_WAYS;
      data_set_bits     <= RST_DSB;
      inst_set_bits     <= RST_ISB;
      write_back        <= RST_WB;
      write_allocate    <= RST_WA;
    end else if (cfg_wen) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SPLIT_MODE:     split_mode        <= cfg_data[0];
        CFG_BLOCK_OFFSET:   block_offset_bits <= cfg_data[2:0];
        CFG_WAYS:           ways              <= cfg_data;
        CFG_DATA_SET_BITS:  data_set_bits     <= cfg_data;
        CFG_INST_SET_BITS:  inst_set_bits     <= cfg_data;
        CFG_WRITE_BACK:     write_back        <= cfg_data[0];
        CFG_WRITE_ALLOCATE: write_allocate    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective geometry.
  logic [2:0]      bo;
  logic [2:0]      wpb_log;
  logic [NW_W-1:0] nw;
  logic [SB_W-1:0] dsb;
  logic [SB_W-1:0] isb;

  always_comb begin
    bo      = (block_offset_bits < 3'd2) ? 3'd2 : block_offset_bits;
    wpb_log = bo - 3'd2;
    if (ways == 4'd0) begin
      nw = NW_W'(1);
    end else if ({1'b0, ways} > NW_W'(MAX_WAYS)) begin
      nw = NW_W'(MAX_WAYS);
    end else begin
      nw = NW_W'(ways);
    end
    dsb = ({1'b0, data_set_bits} > SB_W'(SB_MAX)) ? SB_W'(SB_MAX) : SB_W'(data_set_bits);
    isb = ({1'b0, inst_set_bits} > SB_W'(SB_MAX)) ? SB_W'(SB_MAX) : SB_W'(inst_set_bits);
  end

  // Request decode.
  logic                    accept;
  logic                    req_inst;
  logic [SB_W-1:0]         req_sb;
  logic [ADDR_BITS+31:0]   a_wide;
  logic [ADDR_BITS-1:0]    a_cut;
  logic [ADDR_BITS-1:0]    set_mask;
  logic [SET_W-1:0]        req_set;
  logic [TAG_W-1:0]        req_tag;

  always_comb begin
    req_inst = (cmd_t'(req.cmd) == CMD_FETCH) && split_mode;
    req_sb   = req_inst ? isb : dsb;
    a_wide   = {{ADDR_BITS{1'b0}}, req.addr};
    a_cut    = a_wide[ADDR_BITS-1:0];
    set_mask = (ADDR_BITS'(1) << req_sb) - ADDR_BITS'(1);
    req_set  = SET_W'((a_cut >> bo) & set_mask);
    req_tag  = TAG_W'(a_cut >> (bo + 3'(0) + req_sb));
  end

  // State.
  state_t           state;
  state_t           state_next;
  logic [SET_W-1:0] clr_cnt;
  logic [CNT_W-1:0] fl_cnt;
  logic             fl_pend;
  logic [SET_W-1:0] fl_set;
  logic [LC_W-1:0]  fl_lines;
  logic             acc_inst;
  logic             acc_write;
  logic [SET_W-1:0] acc_set;
  logic [TAG_W-1:0] acc_tag;
  logic             out_valid;
  result_t          out_res;

  logic             fl_issue;
  logic             fl_done;

  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign fl_issue  = (state == ST_FLUSH) && (fl_cnt < CNT_W'(MAX_SETS));
  assign fl_done   = (state == ST_FLUSH) && fl_pend && (fl_cnt == CNT_W'(MAX_SETS));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == SET_W'(MAX_SETS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (cmd_t'(req.cmd) == CMD_FLUSH) ? ST_FLUSH : ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_next = ST_IDLE;
      ST_FLUSH: begin
        if (fl_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // RAMs and their controls.
  logic             d_we;
  logic             i_we;
  logic [SET_W-1:0] waddr;
  logic [ROW_W-1:0] wdata;
  logic             re;
  logic [SET_W-1:0] raddr;
  logic [ROW_W-1:0] d_rdata;
  logic [ROW_W-1:0] i_rdata;
  logic [ROW_W-1:0] reset_row;
  logic [ROW_W-1:0] upd_row;
  logic [ROW_W-1:0] flush_row;
  logic [PC_W-1:0]  row_dirty;
  result_t          upd_res;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      reset_row[w*LINE_W +: LINE_W] = {2'b00, {TAG_W{1'b0}}, AGE_W'(w)};
    end
  end

  // Flush cleans every valid dirty line of a row and counts them.
  always_comb begin
    flush_row = d_rdata;
    row_dirty = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (d_rdata[w*LINE_W + AGE_W + TAG_W + 1] && d_rdata[w*LINE_W + AGE_W + TAG_W]) begin
        flush_row[w*LINE_W + AGE_W + TAG_W] = 1'b0;
        row_dirty = row_dirty + PC_W'(1);
      end
    end
  end

  always_comb begin
    d_we  = 1'b0;
    i_we  = 1'b0;
    waddr = clr_cnt;
    wdata = reset_row;
    re    = 1'b0;
    raddr = req_set;
    unique case (state)
      ST_CLEAR: begin
        d_we = 1'b1;
        i_we = 1'b1;
      end
      ST_IDLE: begin
        re = accept && (cmd_t'(req.cmd) != CMD_FLUSH);
      end
      ST_LOOKUP: begin
        d_we  = !acc_inst;
        i_we  = acc_inst;
        waddr = acc_set;
        wdata = upd_row;
      end
      ST_FLUSH: begin
        re    = fl_issue;
        raddr = fl_cnt[SET_W-1:0];
        d_we  = fl_pend;
        waddr = fl_set;
        wdata = flush_row;
      end
      default: ;
    endcase
  end

  salc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_data_ram (
    .clk, .we(d_we), .waddr, .wdata, .re, .raddr, .rdata(d_rdata)
  );

  salc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_inst_ram (
    .clk, .we(i_we), .waddr, .wdata, .re, .raddr, .rdata(i_rdata)
  );

  salc_update #(.MAX_WAYS(MAX_WAYS), .TAG_W(TAG_W), .AGE_W(AGE_W)) u_update (
    .row_in(acc_inst ? i_rdata : d_rdata),
    .tag(acc_tag),
    .nw,
    .is_write(acc_write),
    .write_back,
    .write_allocate,
    .wpb_log,
    .row_out(upd_row),
    .res(upd_res)
  );

  // Flush total: dirty lines times words per block, saturated.
  logic [LC_W-1:0]  fl_lines_next;
  logic [TOT_W-1:0] fl_words;
  logic [COPY_W-1:0] fl_copy;

  always_comb begin
    fl_lines_next = fl_lines + LC_W'(row_dirty);
    fl_words      = TOT_W'(fl_lines_next) << wpb_log;
    fl_copy       = (fl_words > TOT_W'(COPY_MAX)) ? COPY_MAX : COPY_W'(fl_words);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      fl_cnt    <= '0;
      fl_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
      if (accept) begin
        fl_cnt <= '0;
      end else if (fl_issue) begin
        fl_cnt <= fl_cnt + CNT_W'(1);
      end
      fl_pend <= fl_issue;
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if ((state == ST_LOOKUP) || fl_done) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_inst  <= req_inst;
      acc_write <= (cmd_t'(req.cmd) == CMD_WRITE);
      acc_set   <= req_set;
      acc_tag   <= req_tag;
      fl_lines  <= '0;
    end else if (fl_pend) begin
      fl_lines <= fl_lines_next;
    end
    fl_set <= fl_cnt[SET_W-1:0];
    if (state == ST_LOOKUP) begin
      out_res <= upd_res;
    end else if (fl_done) begin
      out_res <= '{hit: 1'b0, evicted: 1'b0, dirty_evicted: 1'b0,
                   fetch_words: '0, copyback_words: fl_copy};
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.hit            = out_res.hit;
  assign rsp.evicted        = out_res.evicted;
  assign rsp.dirty_evicted  = out_res.dirty_evicted;
  assign rsp.fetch_words    = out_res.fetch_words;
  assign rsp.copyback_words = out_res.copyback_words;
endmodule
`default_nettype wire

// ===== src/salc_checker.sv =====
// Port-level assertions for the cache tag block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module salc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic       rsp_hit,
  input wire logic       rsp_evicted,
  input wire logic       rsp_dirty_evicted,
  input wire logic [5:0] rsp_fetch_words
);
  // No result is shown in the cycle after reset.
  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word valid right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped while stalled");

  // A word is taken only when the result slot has been freed at that edge.
  a_accept_slot: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid)
    else $error("result shown one cycle after accepting a word");

  a_dirty_needs_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_dirty_evicted |-> rsp_evicted)
    else $error("dirty eviction reported without eviction");

  a_hit_no_fill: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_hit |-> !rsp_evicted && (rsp_fetch_words == 6'd0))
    else $error("hit reported together with a line fill");
endmodule

bind set_assoc_lru_cache_tags salc_checker u_salc_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_hit           (rsp.hit),
  .rsp_evicted       (rsp.evicted),
  .rsp_dirty_evicted (rsp.dirty_evicted),
  .rsp_fetch_words   (rsp.fetch_words)
);
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench of the set-associative LRU cache tag block.
`timescale 1ns / 1ps
module testbench;
  import salc_pkg::*;

  localparam int NSETS = DEF_MAX_SETS;
  localparam int NWAYS = DEF_MAX_WAYS;
  localparam int NLINES = NSETS * NWAYS;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  salc_req_if req ();
  salc_rsp_if rsp ();

  set_assoc_lru_cache_tags dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req.sink), .rsp(rsp.source)
  );

  always #2 clk = ~clk;

  // Shadow copy of the tag store; bank 0 is the unified or data part, bank 1 instructions.
  bit line_valid [2][NLINES];
  bit line_dirty [2][NLINES];
  logic [31:0] line_tag [2][NLINES];
  int line_age [2][NLINES];

  logic       cur_split;
  logic [2:0] cur_bo;
  logic [3:0] cur_ways, cur_dsb, cur_isb;
  logic       cur_wb, cur_wa;

  result_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  function automatic int clamp_sets(logic [3:0] bits);
    int sb;
    sb = bits;
    while (sb > 0 && (1 << sb) > NSETS) sb--;
    return sb;
  endfunction

  function automatic void bump_age(int bk, int base, int w);
    int old_age;
    old_age = line_age[bk][base + w];
    for (int k = 0; k < NWAYS; k++)
      if (line_age[bk][base + k] < old_age) line_age[bk][base + k]++;
    line_age[bk][base + w] = 0;
  endfunction

  function automatic result_t cache_outcome(cmd_t c, logic [31:0] a);
    result_t r;
    int bk, sb, bo, nw, wpb, base, victim, way_hit, oldest;
    logic [31:0] tg;
    bit wr;
    int unsigned total;
    r = '0;
    bo = (cur_bo < 2) ? 2 : cur_bo;
    wpb = 1 << (bo - 2);
    if (c == CMD_FLUSH) begin
      total = 0;
      for (int i = 0; i < NLINES; i++)
        if (line_valid[0][i] && line_dirty[0][i]) begin
          line_dirty[0][i] = 1'b0;
          total += wpb;
        end
      r.copyback_words = (total > COPY_MAX) ? COPY_MAX : total[COPY_W-1:0];
      return r;
    end
    bk = (c == CMD_FETCH && cur_split) ? 1 : 0;
    sb = clamp_sets(bk ? cur_isb : cur_dsb);
    nw = (cur_ways == 0) ? 1 : (cur_ways > NWAYS ? NWAYS : cur_ways);
    wr = (c == CMD_WRITE);
    base = ((a >> bo) & ((1 << sb) - 1)) * NWAYS;
    tg = a >> (bo + sb);
    way_hit = -1;
    for (int w = 0; w < nw; w++)
      if (way_hit < 0 && line_valid[bk][base + w] && line_tag[bk][base + w] == tg)
        way_hit = w;
    if (way_hit >= 0) begin
      r.hit = 1'b1;
      if (wr) begin
        if (cur_wb) line_dirty[bk][base + way_hit] = 1'b1;
        else r.copyback_words = 1;
      end
      bump_age(bk, base, way_hit);
      return r;
    end
    if (wr && !cur_wa) begin
      r.copyback_words = 1;
      return r;
    end
    victim = -1;
    for (int w = 0; w < nw; w++)
      if (victim < 0 && !line_valid[bk][base + w]) victim = w;
    if (victim < 0) begin
      victim = 0;
      oldest = line_age[bk][base];
      for (int w = 1; w < nw; w++)
        if (line_age[bk][base + w] > oldest) begin
          oldest = line_age[bk][base + w];
          victim = w;
        end
      r.evicted = 1'b1;
      if (line_dirty[bk][base + victim]) begin
        r.dirty_evicted = 1'b1;
        r.copyback_words = wpb;
      end
    end
    r.fetch_words = wpb;
    line_valid[bk][base + victim] = 1'b1;
    line_tag[bk][base + victim] = tg;
    line_dirty[bk][base + victim] = wr && cur_wb;
    if (wr && !cur_wb) r.copyback_words = r.copyback_words + 1;
    bump_age(bk, base, victim);
    return r;
  endfunction

  // Sends one word; valid stays high afterward so back-to-back words need no extra step.
  task automatic send_access(cmd_t c, logic [31:0] a);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= c;
    req.addr <= a;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(cache_outcome(c, a));
  endtask

  task automatic wait_quiet();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [3:0] v);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      CFG_SPLIT_MODE:     cur_split = v[0];
      CFG_BLOCK_OFFSET:   cur_bo = v[2:0];
      CFG_WAYS:           cur_ways = v;
      CFG_DATA_SET_BITS:  cur_dsb = v;
      CFG_INST_SET_BITS:  cur_isb = v;
      CFG_WRITE_BACK:     cur_wb = v[0];
      CFG_WRITE_ALLOCATE: cur_wa = v[0];
      default: ;
    endcase
  endtask

  task automatic test_default_geometry();
    send_access(CMD_READ, 32'h0);
    send_access(CMD_READ, 32'h0);
    send_access(CMD_WRITE, 32'h4);
    send_access(CMD_READ, 32'h0000_2000);
    send_access(CMD_FETCH, 32'h0000_2008);
    send_access(CMD_WRITE, 32'hFFFF_FFFF);
    send_access(CMD_READ, 32'hFFFF_FFF0);
    send_access(CMD_FLUSH, 32'hFFFF_FFFF);
    send_access(CMD_FLUSH, 32'h0);
    wait_quiet();
  endtask

  task automatic test_extreme_settings();
    write_reg(CFG_SPLIT_MODE, 4'd1);
    write_reg(CFG_BLOCK_OFFSET, 4'd7);
    write_reg(CFG_WAYS, 4'd8);
    write_reg(CFG_DATA_SET_BITS, 4'd0);
    write_reg(CFG_INST_SET_BITS, 4'd10);
    write_reg(CFG_WRITE_BACK, 4'd0);
    write_reg(CFG_WRITE_ALLOCATE, 4'd0);
    send_access(CMD_WRITE, 32'h0000_1000);
    send_access(CMD_READ, 32'h0000_1000);
    send_access(CMD_WRITE, 32'h0000_1004);
    send_access(CMD_FETCH, 32'h0000_1000);
    send_access(CMD_FETCH, 32'h0000_1000);
    for (int i = 0; i < 9; i++) send_access(CMD_READ, i << 16);
    wait_quiet();
    // Out-of-range settings fall back to the clamped geometry.
    write_reg(CFG_WAYS, 4'd0);
    write_reg(CFG_BLOCK_OFFSET, 4'd0);
    write_reg(CFG_DATA_SET_BITS, 4'd15);
    write_reg(CFG_WRITE_BACK, 4'd1);
    write_reg(CFG_WRITE_ALLOCATE, 4'd1);
    send_access(CMD_WRITE, 32'h0000_0040);
    send_access(CMD_WRITE, 32'h0010_0040);
    send_access(CMD_FLUSH, 32'h0);
    wait_quiet();
    write_reg(CFG_WAYS, 4'd15);
    write_reg(CFG_INST_SET_BITS, 4'd15);
    send_access(CMD_FETCH, 32'hABCD_EF00);
    send_access(CMD_READ, 32'hABCD_EF00);
    wait_quiet();
  endtask

  task automatic test_random_phase(int n, bit pause_midway);
    int r;
    logic [31:0] a;
    write_reg(CFG_SPLIT_MODE, $urandom_range(0, 1));
    write_reg(CFG_BLOCK_OFFSET, $urandom_range(0, 7));
    write_reg(CFG_WAYS, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(1, 8));
    write_reg(CFG_DATA_SET_BITS, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                              : $urandom_range(0, 4));
    write_reg(CFG_INST_SET_BITS, $urandom_range(0, 4));
    write_reg(CFG_WRITE_BACK, $urandom_range(0, 1));
    write_reg(CFG_WRITE_ALLOCATE, $urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      // A small address pool keeps sets busy so hits and evictions both occur.
      if ($urandom_range(0, 9) == 0) a = $urandom;
      else a = ($urandom_range(0, 5) << 14) | ($urandom_range(0, 7) << 7) | $urandom_range(0, 127);
      r = $urandom_range(0, 39);
      send_access(r == 0 ? CMD_FLUSH : cmd_t'(r % 3), a);
      if (pause_midway && i == n / 2) wait_quiet();
    end
    wait_quiet();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 17);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        want = pending_results.pop_front();
        if (rsp.hit !== want.hit || rsp.evicted !== want.evicted ||
            rsp.dirty_evicted !== want.dirty_evicted ||
            rsp.fetch_words !== want.fetch_words ||
            rsp.copyback_words !== want.copyback_words) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch cycle %0d: expected h%0b e%0b d%0b f%0d c%0d, got h%0b e%0b d%0b f%0d c%0d",
                     cycles, want.hit, want.evicted, want.dirty_evicted, want.fetch_words,
                     want.copyback_words, rsp.hit, rsp.evicted, rsp.dirty_evicted,
                     rsp.fetch_words, rsp.copyback_words);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    req.valid <= 1'b0;
    req.cmd <= '0;
    req.addr <= '0;
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < NLINES; i++) begin
        line_valid[b][i] = 1'b0;
        line_dirty[b][i] = 1'b0;
        line_tag[b][i] = '0;
        line_age[b][i] = i % NWAYS;
      end
    cur_split = RST_SPLIT;
    cur_bo = RST_BO;
    cur_ways = RST_WAYS;
    cur_dsb = RST_DSB;
    cur_isb = RST_ISB;
    cur_wb = RST_WB;
    cur_wa = RST_WA;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_default_geometry();
    test_extreme_settings();
    for (int p = 0; p < 4; p++) test_random_phase(110, p == 1);
    idle_on = 1'b0;
    test_random_phase(90, 1'b0);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
